// ----- rtl/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/m4i_pkg.sv -----
// shared types, constants and address helpers for the 4x4 matrix inverse
package m4i_pkg;

  localparam int ELEM_W        = 32;
  localparam int ADJ_W         = 100;  // exact cofactor width
  localparam int DET_W         = 136;  // exact determinant width
  localparam int CHUNK_W       = 32;
  localparam int PROD_W        = 65;
  localparam int DIV_STEPS     = 33;   // quotient bits kept
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [DIV_STEPS-1:0] Q_LIM_POS = 33'h0_7fff_ffff;
  localparam logic [DIV_STEPS-1:0] Q_LIM_NEG = 33'h0_8000_0000;

  typedef enum logic [3:0] {
    S_LOAD,
    S_COF,
    S_DET,
    S_DRD,
    S_DSET,
    S_DSTART,
    S_DWAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic done;
    logic big;
  } div_sts_t;

  // store address of minor element (i, j) for cofactor k = 4*c + r
  function automatic logic [3:0] elem_addr(input logic [3:0] k, input logic [1:0] i,
                                           input logic [1:0] j);
    logic [1:0] f;
    logic [1:0] s;
    f = (i < k[1:0]) ? i : i + 2'd1;
    s = (j < k[3:2]) ? j : j + 2'd1;
    return {f, s};
  endfunction

  // minor position {i, j} of the 2x2 operands: m = a1*b1 - a2*b2
  function automatic logic [3:0] pair_pos(input logic [1:0] term, input logic [1:0] slot);
    logic [3:0] p;
    case ({term, slot})
      4'b00_00: p = {2'd1, 2'd1};
      4'b00_01: p = {2'd2, 2'd2};
      4'b00_10: p = {2'd1, 2'd2};
      4'b00_11: p = {2'd2, 2'd1};
      4'b01_00: p = {2'd1, 2'd0};
      4'b01_01: p = {2'd2, 2'd2};
      4'b01_10: p = {2'd1, 2'd2};
      4'b01_11: p = {2'd2, 2'd0};
      4'b10_00: p = {2'd1, 2'd0};
      4'b10_01: p = {2'd2, 2'd1};
      4'b10_10: p = {2'd1, 2'd1};
      4'b10_11: p = {2'd2, 2'd0};
      default:  p = '0;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/m4i_div.sv -----
// restoring divider for the scaled cofactor over the determinant magnitude
module m4i_div import m4i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ADJ_W+2*FRAC_BITS-1:0] num,
  input  logic [DET_W-1:0]     dmag,
  output logic [DIV_STEPS-1:0] q,
  output div_sts_t             sts
);

  localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;
  localparam int HI_W  = NUM_W - DIV_STEPS;
  localparam int CMP_W = (HI_W > DET_W) ? HI_W : DET_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [DET_W-1:0]     rem_r;
  logic [DIV_STEPS-1:0] nlow_r;
  logic [DIV_STEPS-1:0] q_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 big_r;

  logic [CMP_W-1:0]     hi;
  logic                 big;
  logic [DET_W:0]       trial;
  logic                 ge;
  logic [DET_W-1:0]     rem_nxt;

  always_comb begin
    hi      = CMP_W'(num >> DIV_STEPS);
    big     = hi >= CMP_W'(dmag);
    trial   = {rem_r, nlow_r[DIV_STEPS-1]};
    ge      = trial >= {1'b0, dmag};
    rem_nxt = ge ? DET_W'(trial - {1'b0, dmag}) : DET_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      big_r  <= big;
      rem_r  <= DET_W'(hi);
      nlow_r <= num[DIV_STEPS-1:0];
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      nlow_r <= nlow_r << 1;
      q_r    <= {q_r[DIV_STEPS-2:0], ge};
    end
  end

  assign q        = q_r;
  assign sts.done = done_r;
  assign sts.big  = big_r;

endmodule

// ----- rtl/matrix4_inverse.sv -----
// 4x4 matrix inverse by cofactors, signed fixed point with saturation
//
// input channel: in_valid / in_stall, one element per transfer, column-major
// (index = 4*col + row), signed with FRAC_BITS fraction bits. 16 transfers
// make one matrix; in_stall stays low while a matrix is loading.
// output channel: out_valid / out_stall, 16 inverse elements per matrix in
// the same order, out_last_element on the sixteenth. out_singular marks a
// zero determinant (values are then zero); out_saturated marks a clipped one.
// after the 16th element in_stall rises while the block works: each cofactor
// goes through one shared 32x33 multiplier reading the element memory, then
// the determinant, then each element through the 33-step restoring divider;
// the pace is set by the single multiplier and the one-bit-per-cycle divider.
// the output register holds a result while out_stall is high and the block
// waits on it; input stays stalled until the last result is loaded.
// rst_n (synchronous, low) returns to loading element 0 and drops out_valid;
// element and cofactor memories are not cleared.
module matrix4_inverse import m4i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEM_W-1:0] out_inverse_value,
  output logic                     out_singular,
  output logic                     out_saturated,
  output logic                     out_last_element
);

  localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;

  // memories
  logic [ELEM_W-1:0] mat_mem [16];
  logic [ADJ_W-1:0]  adj_mem [16];
  logic signed [ELEM_W-1:0] mat_rd_r;
  logic signed [ADJ_W-1:0]  adj_rd_r;
  logic [3:0] mat_raddr;
  logic [3:0] adj_raddr;
  logic       mat_we;
  logic       adj_we;

  state_t state_r, state_nxt;
  logic [3:0] load_cnt_r, load_cnt_nxt;
  logic [3:0] k_r, k_nxt;
  logic [1:0] term_r, term_nxt;
  logic [3:0] ph_r, ph_nxt;

  logic signed [ELEM_W-1:0] opa_r, opa_nxt;
  logic signed [ADJ_W-1:0]  breg_r, breg_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     pend_r, pend_nxt;
  logic [1:0]               pend_sh_r, pend_sh_nxt;
  logic                     pend_neg_r, pend_neg_nxt;
  logic signed [DET_W-1:0]  acc_r, acc_nxt;
  logic [DET_W-1:0]         dmag_r, dmag_nxt;
  logic                     det_neg_r, det_neg_nxt;
  logic                     singular_r, singular_nxt;
  logic                     neg_r, neg_nxt;
  logic [NUM_W-1:0]         num_r, num_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [ELEM_W-1:0] out_val_r;
  logic                     out_sing_r;
  logic                     out_sat_r;
  logic                     out_last_r;
  logic                     out_ld;

  // multiplier operand select
  logic                     mul_mem;
  logic [1:0]               chunk;
  logic signed [32:0]       mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [DET_W-1:0]  addend;
  logic                     term_neg;
  logic [3:0]               pp;
  logic [ADJ_W-1:0]         mag;

  logic                     div_start;
  logic [DIV_STEPS-1:0]     div_q;
  div_sts_t                 div_sts;

  logic                     res_sat;
  logic signed [ELEM_W-1:0] res_val;

  always_comb begin
    case (chunk)
      2'd0:    mul_b = {1'b0, breg_r[CHUNK_W-1:0]};
      2'd1:    mul_b = {1'b0, breg_r[2*CHUNK_W-1:CHUNK_W]};
      2'd2:    mul_b = {1'b0, breg_r[3*CHUNK_W-1:2*CHUNK_W]};
      default: mul_b = 33'($signed(breg_r[ADJ_W-1:3*CHUNK_W]));
    endcase
    if (mul_mem) begin
      mul_b = 33'(mat_rd_r);
    end
    mul_p  = opa_r * mul_b;
    addend = DET_W'(prod_r) << {pend_sh_r, 5'd0};
  end

  // result formatting from the divider
  always_comb begin
    res_sat = div_sts.big || (neg_r ? (div_q > Q_LIM_NEG) : (div_q > Q_LIM_POS));
    if (singular_r) begin
      res_sat = 1'b0;
      res_val = '0;
    end else if (res_sat) begin
      res_val = neg_r ? ELEM_W'(Q_LIM_NEG) : ELEM_W'(Q_LIM_POS);
    end else begin
      res_val = neg_r ? -ELEM_W'(div_q) : ELEM_W'(div_q);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    k_nxt        = k_r;
    term_nxt     = term_r;
    ph_nxt       = ph_r;
    opa_nxt      = opa_r;
    breg_nxt     = breg_r;
    prod_nxt     = prod_r;
    pend_nxt     = 1'b0;
    pend_sh_nxt  = pend_sh_r;
    pend_neg_nxt = pend_neg_r;
    acc_nxt      = pend_r ? (pend_neg_r ? acc_r - addend : acc_r + addend) : acc_r;
    dmag_nxt     = dmag_r;
    det_neg_nxt  = det_neg_r;
    singular_nxt = singular_r;
    neg_nxt      = neg_r;
    num_nxt      = num_r;
    mat_raddr    = '0;
    adj_raddr    = '0;
    mat_we       = 1'b0;
    adj_we       = 1'b0;
    mul_mem      = 1'b0;
    chunk        = '0;
    div_start    = 1'b0;
    out_ld       = 1'b0;
    mag          = '0;
    term_neg     = k_r[0] ^ k_r[2] ^ (term_r == 2'd1);
    pp           = pair_pos(term_r, ph_r[1:0]);

    case (state_r)
      S_LOAD: begin
        acc_nxt = '0;
        if (in_valid) begin
          mat_we       = 1'b1;
          load_cnt_nxt = load_cnt_r + 1'b1;
          if (load_cnt_r == 4'd15) begin
            state_nxt = S_COF;
            k_nxt     = '0;
            term_nxt  = '0;
            ph_nxt    = '0;
          end
        end
      end

      S_COF: begin
        ph_nxt = ph_r + 1'b1;
        case (ph_r)
          4'd0: begin
            mat_raddr = elem_addr(k_r, pp[3:2], pp[1:0]);
          end
          4'd1: begin
            opa_nxt   = mat_rd_r;
            mat_raddr = elem_addr(k_r, pp[3:2], pp[1:0]);
          end
          4'd2: begin
            mul_mem   = 1'b1;
            prod_nxt  = mul_p;
            mat_raddr = elem_addr(k_r, pp[3:2], pp[1:0]);
          end
          4'd3: begin
            breg_nxt  = ADJ_W'(prod_r);
            opa_nxt   = mat_rd_r;
            mat_raddr = elem_addr(k_r, pp[3:2], pp[1:0]);
          end
          4'd4: begin
            mul_mem   = 1'b1;
            prod_nxt  = mul_p;
            mat_raddr = elem_addr(k_r, 2'd0, term_r);
          end
          4'd5: begin
            breg_nxt = breg_r - ADJ_W'(prod_r);
            opa_nxt  = mat_rd_r;
          end
          4'd6, 4'd7, 4'd8, 4'd9: begin
            chunk        = 2'(ph_r - 4'd6);
            prod_nxt     = mul_p;
            pend_nxt     = 1'b1;
            pend_sh_nxt  = chunk;
            pend_neg_nxt = term_neg;
          end
          4'd10: begin
            // last chunk lands in the accumulator this cycle
            if (term_r != 2'd2) begin
              term_nxt = term_r + 1'b1;
              ph_nxt   = '0;
            end
          end
          default: begin
            adj_we   = 1'b1;
            acc_nxt  = '0;
            term_nxt = '0;
            ph_nxt   = '0;
            k_nxt    = k_r + 1'b1;
            if (k_r == 4'd15) begin
              state_nxt = S_DET;
            end
          end
        endcase
      end

      S_DET: begin
        ph_nxt = ph_r + 1'b1;
        case (ph_r)
          4'd0: begin
            mat_raddr = {2'd0, k_r[1:0]};
            adj_raddr = {k_r[1:0], 2'd0};
          end
          4'd1: begin
            opa_nxt  = mat_rd_r;
            breg_nxt = adj_rd_r;
          end
          4'd2, 4'd3, 4'd4, 4'd5: begin
            chunk        = 2'(ph_r - 4'd2);
            prod_nxt     = mul_p;
            pend_nxt     = 1'b1;
            pend_sh_nxt  = chunk;
            pend_neg_nxt = 1'b0;
          end
          4'd6: begin
            if (k_r[1:0] != 2'd3) begin
              k_nxt  = k_r + 1'b1;
              ph_nxt = '0;
            end
          end
          default: begin
            singular_nxt = (acc_r == '0);
            det_neg_nxt  = acc_r[DET_W-1];
            dmag_nxt     = acc_r[DET_W-1] ? DET_W'(-acc_r) : DET_W'(acc_r);
            k_nxt        = '0;
            ph_nxt       = '0;
            state_nxt    = S_DRD;
          end
        endcase
      end

      S_DRD: begin
        adj_raddr = k_r;
        state_nxt = S_DSET;
      end

      S_DSET: begin
        mag       = adj_rd_r[ADJ_W-1] ? ADJ_W'(-adj_rd_r) : ADJ_W'(adj_rd_r);
        neg_nxt   = adj_rd_r[ADJ_W-1] ^ det_neg_r;
        num_nxt   = NUM_W'(mag) << (2 * FRAC_BITS);
        state_nxt = singular_r ? S_EMIT : S_DSTART;
      end

      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end

      S_DWAIT: begin
        if (div_sts.done) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_ld = 1'b1;
          k_nxt  = k_r + 1'b1;
          state_nxt = (k_r == 4'd15) ? S_LOAD : S_DRD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      k_r         <= '0;
      term_r      <= '0;
      ph_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      k_r         <= k_nxt;
      term_r      <= term_nxt;
      ph_r        <= ph_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opa_r      <= opa_nxt;
    breg_r     <= breg_nxt;
    prod_r     <= prod_nxt;
    pend_sh_r  <= pend_sh_nxt;
    pend_neg_r <= pend_neg_nxt;
    acc_r      <= acc_nxt;
    dmag_r     <= dmag_nxt;
    det_neg_r  <= det_neg_nxt;
    singular_r <= singular_nxt;
    neg_r      <= neg_nxt;
    num_r      <= num_nxt;
    if (out_ld) begin
      out_val_r  <= res_val;
      out_sing_r <= singular_r;
      out_sat_r  <= res_sat;
      out_last_r <= (k_r == 4'd15);
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[load_cnt_r] <= in_element_value;
    end
    mat_rd_r <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[k_r] <= acc_r[ADJ_W-1:0];
    end
    adj_rd_r <= adj_mem[adj_raddr];
  end

  m4i_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (num_r),
    .dmag (dmag_r),
    .q    (div_q),
    .sts  (div_sts)
  );

  assign in_stall          = (state_r != S_LOAD);
  assign out_valid         = out_valid_r;
  assign out_inverse_value = out_val_r;
  assign out_singular      = out_sing_r;
  assign out_saturated     = out_sat_r;
  assign out_last_element  = out_last_r;

endmodule

// ----- rtl/m4i_checker.sv -----
// port-level checks for the matrix inverse, bound to the top level
`include "assert_macros.svh"

module m4i_checker import m4i_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [ELEM_W-1:0] out_inverse_value,
  input logic                     out_singular,
  input logic                     out_saturated,
  input logic                     out_last_element
);

  // a stalled result stays offered
  `ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

  // singular matrix gives plain zeros
  `ASSERT_IMP(a_sing_zero, out_valid && out_singular, out_inverse_value == 0 && !out_saturated)

  // clipped values sit on a rail
  `ASSERT_IMP(a_sat_rail, out_valid && out_saturated, out_inverse_value == 32'sh7fffffff || out_inverse_value == 32'sh80000000)

  // the last transfer is not directly followed by another result
  `ASSERT_NXT(a_last_gap, out_valid && out_last_element && !out_stall, !out_valid)

endmodule

bind matrix4_inverse m4i_checker u_m4i_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_inverse_value(out_inverse_value),
  .out_singular     (out_singular),
  .out_saturated    (out_saturated),
  .out_last_element (out_last_element)
);

// ----- sim/matrix4_inverse_tb.sv -----
// self-checking testbench for the 4x4 fixed-point matrix inverse
module matrix4_inverse_tb import m4i_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int N_MATRICES = 26;
  localparam int CALM_AFTER = 350;  // accepted elements before idling stops

  typedef logic signed [199:0] wide_t;

  typedef struct {
    logic signed [ELEM_W-1:0] value;
    logic singular;
    logic saturated;
    logic last;
  } inv_elem_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [ELEM_W-1:0] in_element_value;
  logic out_valid;
  logic out_stall;
  logic signed [ELEM_W-1:0] out_inverse_value;
  logic out_singular;
  logic out_saturated;
  logic out_last_element;

  matrix4_inverse uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_element_value(in_element_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_inverse_value(out_inverse_value), .out_singular(out_singular),
    .out_saturated(out_saturated), .out_last_element(out_last_element)
  );

  logic signed [ELEM_W-1:0] element_queue[$];
  inv_elem_t inverse_queue[$];
  logic signed [ELEM_W-1:0] shadow_matrix[16];
  int unsigned shadow_count;
  int errors;
  int accepted_elems;
  bit took_element;
  int send_gap;
  int recv_gap;
  int hold_off;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // 3x3 minor leaving out first index rf and second index cs
  function automatic wide_t minor_det(int rf, int cs);
    wide_t x[3][3];
    int i;
    int j;
    i = 0;
    for (int f = 0; f < 4; f++) begin
      if (f == rf) continue;
      j = 0;
      for (int s = 0; s < 4; s++) begin
        if (s == cs) continue;
        x[i][j] = shadow_matrix[f * 4 + s];
        j++;
      end
      i++;
    end
    return x[0][0] * (x[1][1] * x[2][2] - x[1][2] * x[2][1])
         - x[0][1] * (x[1][0] * x[2][2] - x[1][2] * x[2][0])
         + x[0][2] * (x[1][0] * x[2][1] - x[1][1] * x[2][0]);
  endfunction

  task automatic predict_inverse(input logic signed [ELEM_W-1:0] elem);
    wide_t adj[16];
    wide_t det;
    wide_t q;
    inv_elem_t e;
    shadow_matrix[shadow_count] = elem;
    shadow_count = (shadow_count + 1) % 16;
    if (shadow_count != 0) return;
    det = '0;
    for (int k = 0; k < 16; k++) begin
      adj[k] = minor_det(k & 3, k >> 2);
      if (((k & 3) + (k >> 2)) % 2 == 1) adj[k] = -adj[k];
    end
    for (int k = 0; k < 4; k++) det = det + wide_t'(shadow_matrix[k]) * adj[k * 4];
    for (int k = 0; k < 16; k++) begin
      e.singular = (det == 0);
      e.saturated = 1'b0;
      e.value = '0;
      e.last = (k == 15);
      if (det != 0) begin
        q = (adj[k] <<< (2 * FRAC)) / det;
        if (q > wide_t'(32'sh7fffffff)) begin
          e.value = 32'sh7fffffff;
          e.saturated = 1'b1;
        end else if (q < -wide_t'(64'sh80000000)) begin
          e.value = 32'sh80000000;
          e.saturated = 1'b1;
        end else begin
          e.value = q[31:0];
        end
      end
      inverse_queue.push_back(e);
    end
  endtask

  // accept side: prediction on input transfer, compare on output transfer
  always @(posedge clk) begin
    took_element <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_inverse(in_element_value);
      accepted_elems <= accepted_elems + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (inverse_queue.size() == 0) begin
        $display("%0t: unexpected result value=%h", $realtime, out_inverse_value);
        errors++;
      end else begin
        inv_elem_t e;
        e = inverse_queue.pop_front();
        if (out_inverse_value !== e.value || out_singular !== e.singular ||
            out_saturated !== e.saturated || out_last_element !== e.last) begin
          $display("%0t: mismatch exp val=%h sing=%b sat=%b last=%b act val=%h sing=%b sat=%b last=%b",
                   $realtime, e.value, e.singular, e.saturated, e.last,
                   out_inverse_value, out_singular, out_saturated, out_last_element);
          errors++;
        end
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (took_element) void'(element_queue.pop_front());
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall && !took_element) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (element_queue.size() > 0) begin
      if (accepted_elems < CALM_AFTER && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 9) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_element_value <= element_queue[0];
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_elems >= 100) begin
      hold_done <= 1'b1;
      hold_off <= 3000;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else if (accepted_elems < CALM_AFTER && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_matrix(input logic signed [ELEM_W-1:0] m[16]);
    for (int i = 0; i < 16; i++) element_queue.push_back(m[i]);
  endtask

  function automatic logic signed [ELEM_W-1:0] small_rand(int unsigned mag);
    return $signed($urandom_range(0, 2 * mag)) - $signed(mag);
  endfunction

  initial begin
    logic signed [ELEM_W-1:0] m[16];
    int src;
    int dst;
    errors = 0;
    accepted_elems = 0;
    shadow_count = 0;
    took_element = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    hold_off = 0;
    hold_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_element_value = '0;
    out_stall = 1'b0;
    for (int i = 0; i < 16; i++) shadow_matrix[i] = '0;

    // diagonal of extremes: clips both ways, plus the full-range corners
    for (int i = 0; i < 16; i++) m[i] = '0;
    m[0] = 32'sd1;
    m[5] = -32'sd1;
    m[10] = 32'sh7fffffff;
    m[15] = 32'sh80000000;
    queue_matrix(m);

    for (int n = 0; n < N_MATRICES - 1; n++) begin
      case ($urandom_range(0, 6))
        0: for (int i = 0; i < 16; i++) m[i] = $urandom;
        1: for (int i = 0; i < 16; i++) m[i] = small_rand(1 << 18);
        2: begin
          for (int i = 0; i < 16; i++) m[i] = small_rand(1 << 14);
          for (int i = 0; i < 4; i++) m[i * 5] = small_rand(1 << 20) + (1 << 21);
        end
        3: begin
          // two equal columns give a zero determinant
          for (int i = 0; i < 16; i++) m[i] = small_rand(1 << 20);
          src = $urandom_range(0, 3);
          dst = (src + $urandom_range(1, 3)) % 4;
          for (int r = 0; r < 4; r++) m[dst * 4 + r] = m[src * 4 + r];
        end
        4: begin
          for (int i = 0; i < 16; i++) m[i] = '0;
          if ($urandom_range(0, 1)) for (int i = 0; i < 4; i++) m[i * 5] = 32'sh10000;
        end
        5: for (int i = 0; i < 16; i++) m[i] = small_rand(3);
        default: for (int i = 0; i < 16; i++) m[i] = small_rand(1 << 17);
      endcase
      queue_matrix(m);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (element_queue.size() == 0 && inverse_queue.size() == 0);
    repeat (2000) @(posedge clk);
    if (errors == 0 && inverse_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
